[rtl/core/gift_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GIFT-64 package
// Shared types, S-box tables, the bit permutation and the key schedule of the
// GIFT-64 cipher with a 128-bit key.
// ----------------------------------------------------------------------------
package gift_pkg;

	// Largest number of rounds that the key schedule provides.
	localparam int MAX_ROUNDS = 28;

	typedef logic [63:0] word_t;
	typedef logic [3:0]  nib_t;
	typedef logic [MAX_ROUNDS-1:0][63:0] rk_arr_t;

	// Register indexes of the configuration port.
	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	// Forward and inverse S-boxes.
	localparam nib_t SBOX_FWD [16] = '{
		4'h1, 4'hA, 4'h4, 4'hC, 4'h6, 4'hF, 4'h3, 4'h9,
		4'h2, 4'hD, 4'hB, 4'h7, 4'h5, 4'h0, 4'h8, 4'hE
	};
	localparam nib_t SBOX_BWD [16] = '{
		4'hD, 4'h0, 4'h8, 4'h6, 4'h2, 4'hC, 4'h4, 4'hB,
		4'hE, 4'h7, 4'h1, 4'hA, 4'h3, 4'h9, 4'hF, 4'h5
	};

	// Substitution of all sixteen nibbles with the forward S-box.
	function automatic word_t sub_fwd(word_t s);
		word_t o;
		o = '0;
		for (int n = 0; n < 16; n++) begin
			o[4*n +: 4] = SBOX_FWD[s[4*n +: 4]];
		end
		return o;
	endfunction

	// Substitution of all sixteen nibbles with the inverse S-box.
	function automatic word_t sub_bwd(word_t s);
		word_t o;
		o = '0;
		for (int n = 0; n < 16; n++) begin
			o[4*n +: 4] = SBOX_BWD[s[4*n +: 4]];
		end
		return o;
	endfunction

	// Destination of source bit i under the GIFT-64 permutation.
	function automatic int bit_dest(int i);
		int q;
		int r;
		q = i >> 4;
		r = i & 15;
		return 4 * q + 16 * ((3 * (r >> 2) + (r & 3)) & 3) + (i & 3);
	endfunction

	// Forward bit permutation; pure wiring.
	function automatic word_t perm_fwd(word_t s);
		word_t o;
		o = '0;
		for (int i = 0; i < 64; i++) begin
			o[bit_dest(i)] = s[i];
		end
		return o;
	endfunction

	// Inverse bit permutation; pure wiring.
	function automatic word_t perm_bwd(word_t s);
		word_t o;
		o = '0;
		for (int i = 0; i < 64; i++) begin
			o[i] = s[bit_dest(i)];
		end
		return o;
	endfunction

	// Full set of round keys. The key update is only a rearrangement of
	// words and the round constants are fixed, so this is wiring and XOR
	// with constants.
	function automatic rk_arr_t round_keys(word_t lo_in, word_t hi_in);
		rk_arr_t      rk;
		word_t        lo;
		word_t        hi;
		word_t        k;
		logic [15:0]  u;
		logic [15:0]  v;
		logic [15:0]  n0;
		logic [15:0]  n1;
		logic [5:0]   rc;
		lo = lo_in;
		hi = hi_in;
		rc = '0;
		for (int r = 0; r < MAX_ROUNDS; r++) begin
			v  = lo[15:0];
			u  = lo[31:16];
			rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
			k  = 64'h8000_0000_0000_0000;
			for (int i = 0; i < 16; i++) begin
				k[4*i]     = k[4*i] ^ v[i];
				k[4*i + 1] = k[4*i + 1] ^ u[i];
			end
			for (int i = 0; i < 6; i++) begin
				k[4*i + 3] = k[4*i + 3] ^ rc[i];
			end
			rk[r] = k;
			n0 = {v[11:0], v[15:12]};
			n1 = {u[1:0], u[15:2]};
			lo = {hi[31:0], lo[63:32]};
			hi = {n1, n0, hi[63:32]};
		end
		return rk;
	endfunction

endpackage
`default_nettype wire

[rtl/core/gift64_block_cipher.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GIFT-64 block cipher
// Fully unrolled pipeline with one cipher round in each stage, encrypting or
// decrypting one 64-bit block per request with a 128-bit key.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the pipeline can
// advance, so blocks may follow each other back to back in either
// direction. Each request passes through ROUNDS pipeline stages, one cipher
// round per stage, and its result is presented from the last stage. When
// the output is not taken the pipeline fills up and stalls without losing
// data. The key registers sit on the APB port at byte addresses 0 (key bits
// 63..0) and 8 (key bits 127..64) and must only be written while no request
// is in flight.
module gift64_block_cipher #(
	parameter int ROUNDS = 28
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// Configuration port
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [3:0]          paddr,
	input  wire  [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	// Input channel
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 action,
	input  wire  gift_pkg::word_t block_in,
	// Output channel
	output logic                out_valid,
	input  wire                 out_ready,
	output gift_pkg::word_t     block_out
);
	import gift_pkg::*;

	word_t              key_low_q;
	word_t              key_high_q;
	rk_arr_t            rk_all;

	logic [ROUNDS-1:0]  valid_s;
	logic [ROUNDS-1:0]  act_s;
	word_t              state_s  [ROUNDS];

	logic [ROUNDS:0]    adv;
	logic [ROUNDS-1:0]  stg_valid;
	logic [ROUNDS-1:0]  stg_act;
	word_t              stg_data [ROUNDS];
	word_t              stg_next [ROUNDS];

	// Key registers, written in the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3])
				REG_KEY_LOW:  key_low_q  <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Register read-back; the port never inserts wait states.
	always_comb begin
		case (paddr[3])
			REG_KEY_LOW:  prdata = key_low_q;
			REG_KEY_HIGH: prdata = key_high_q;
			default:      prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	// Round keys follow the key registers directly.
	always_comb begin
		rk_all = round_keys(key_low_q, key_high_q);
	end

	// A stage may load when it is empty or when the stage after it moves.
	assign adv[ROUNDS] = out_ready;
	genvar g;
	generate
		for (g = 0; g < ROUNDS; g++) begin : g_stage
			assign adv[g] = !valid_s[g] || adv[g+1];
			if (g == 0) begin : g_first
				assign stg_valid[g] = in_valid;
				assign stg_act[g]   = action;
				assign stg_data[g]  = block_in;
			end else begin : g_rest
				assign stg_valid[g] = valid_s[g-1];
				assign stg_act[g]   = act_s[g-1];
				assign stg_data[g]  = state_s[g-1];
			end
		end
	endgenerate

	// One round per stage: encryption uses round key g, decryption runs the
	// inverse round with the keys in reverse order.
	always_comb begin
		for (int k = 0; k < ROUNDS; k++) begin
			if (stg_act[k]) begin
				stg_next[k] = sub_bwd(perm_bwd(stg_data[k] ^ rk_all[ROUNDS-1-k]));
			end else begin
				stg_next[k] = perm_fwd(sub_fwd(stg_data[k])) ^ rk_all[k];
			end
		end
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int k = 0; k < ROUNDS; k++) begin
				if (adv[k]) begin
					valid_s[k] <= stg_valid[k];
				end
			end
		end
	end

	// Payload of the pipeline, loaded only with a live request.
	always_ff @(posedge clk) begin
		for (int k = 0; k < ROUNDS; k++) begin
			if (adv[k] && stg_valid[k]) begin
				state_s[k] <= stg_next[k];
				act_s[k]   <= stg_act[k];
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_s[ROUNDS-1];
	assign block_out = state_s[ROUNDS-1];

endmodule
`default_nettype wire
